// ===== rtl/s256_pkg.sv =====
package s256_pkg;

    localparam int unsigned RoundCount = 64;

    typedef logic [31:0] t_word;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
    } t_req;

    localparam t_word RoundK [RoundCount] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam t_word InitHash [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PadByte = 8'h80;
    localparam logic [5:0] LenStart = 6'd56;

    localparam logic ActAbsorb = 1'b0;
    localparam logic ActFinish = 1'b1;

    function automatic t_word ror(input t_word x, input int unsigned r);
        ror = (x >> r) | (x << (32 - r));
    endfunction

endpackage

// ===== rtl/sha256_byte_stream_hash_core.sv =====
// sha-256 byte stream hasher
// input channel: i_valid/o_ready with i_action and i_data_byte; absorb
// requests carry one message byte, a finish request pads the message and
// produces the digest
// output channel: o_valid/i_ready with o_digest_word, o_word_index and
// o_last_word; eight words per finish, word 0 first
// a four-entry request queue sits in front of the engine, so requests are
// taken while the engine compresses or while digest words wait
// an absorb stores one byte; every 64th byte starts the 64 rounds of the
// single round unit and the final hash add
// a finish writes the pad byte, zero padding and the length, then runs the
// rounds; a second block follows when more than 55 bytes were buffered,
// and the digest words follow, each held until it is accepted
// reset loads the initial hash value and clears both counters and the queue
// a stalled receiver holds the current digest word; the queue then fills
// and o_ready falls
module sha256_byte_stream_hash_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_action,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    import s256_pkg::*;

    t_req w_in, w_q;
    logic w_qv, w_qr;

    assign w_in.action    = i_action;
    assign w_in.data_byte = i_data_byte;

    s256_fifo u_fifo (
        .i_clk, .i_rst_n,
        .i_valid (i_valid), .o_ready (o_ready), .i_req (w_in),
        .o_valid (w_qv), .i_ready (w_qr), .o_req (w_q)
    );

    s256_engine u_engine (
        .i_clk, .i_rst_n,
        .i_valid (w_qv), .o_ready (w_qr), .i_req (w_q),
        .o_valid, .i_ready, .o_digest_word, .o_word_index, .o_last_word
    );

endmodule

// ===== rtl/s256_fifo.sv =====
module s256_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  s256_pkg::t_req  i_req,
    output logic            o_valid,
    input  logic            i_ready,
    output s256_pkg::t_req  o_req
);
    import s256_pkg::*;

    t_req       r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       w_push, w_pop;

    assign o_ready = (r_cnt != 3'd4);
    assign o_valid = (r_cnt != 3'd0);
    assign o_req   = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_req;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 2'd1;
            if (w_pop)  r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'b0, w_push} - {2'b0, w_pop};
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4) else $error("queue count overflow");
    a_full_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 3'd4 && !w_pop) |=> r_cnt == 3'd4) else $error("queue lost entry");
    a_empty_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 3'd0) |-> !o_valid) else $error("valid while empty");

endmodule

// ===== rtl/s256_engine.sv =====
module s256_engine (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  s256_pkg::t_req  i_req,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [31:0]     o_digest_word,
    output logic [2:0]      o_word_index,
    output logic            o_last_word
);
    import s256_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PADZ  = 6'b000010,
        S_LEN   = 6'b000100,
        S_ROUND = 6'b001000,
        S_ADD   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state      r_state, n_state;
    t_word       r_h [8];
    t_word       r_v [8];
    t_word       r_w [16];
    logic [5:0]  r_cnt;
    logic [63:0] r_bits;
    logic [5:0]  r_rnd;
    logic        r_fin;
    logic        r_two;
    logic [2:0]  r_oidx;

    t_word w_wt, w_s0, w_s1, w_t1, w_t2, w_new;
    t_word w_e, w_a;
    logic  w_take;

    assign o_ready = (r_state == S_IDLE);
    assign w_take  = i_valid && o_ready;
    assign o_valid = (r_state == S_OUT);
    assign o_digest_word = r_h[r_oidx];
    assign o_word_index  = r_oidx;
    assign o_last_word   = (r_oidx == 3'd7);

    assign w_s0  = ror(r_w[1], 7) ^ ror(r_w[1], 18) ^ (r_w[1] >> 3);
    assign w_s1  = ror(r_w[14], 17) ^ ror(r_w[14], 19) ^ (r_w[14] >> 10);
    assign w_new = w_s1 + r_w[9] + w_s0 + r_w[0];
    assign w_wt  = r_w[0];
    assign w_e   = r_v[4];
    assign w_a   = r_v[0];
    assign w_t1  = r_v[7] + (ror(w_e, 6) ^ ror(w_e, 11) ^ ror(w_e, 25))
                 + ((w_e & r_v[5]) ^ (~w_e & r_v[6])) + RoundK[r_rnd] + w_wt;
    assign w_t2  = (ror(w_a, 2) ^ ror(w_a, 13) ^ ror(w_a, 22))
                 + ((w_a & r_v[1]) ^ (w_a & r_v[2]) ^ (r_v[1] & r_v[2]));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    if (i_req.action == ActFinish) begin
                        if (r_cnt == 6'd63)      n_state = S_ROUND;
                        else if (r_cnt == 6'd55) n_state = S_LEN;
                        else                     n_state = S_PADZ;
                    end else if (r_cnt == 6'd63) begin
                        n_state = S_ROUND;
                    end
                end
            end
            S_PADZ: begin
                if (r_cnt == 6'd63)         n_state = S_ROUND;
                else if (r_cnt == 6'd55 && !r_two) n_state = S_LEN;
            end
            S_LEN:   if (r_cnt == 6'd63) n_state = S_ROUND;
            S_ROUND: if (r_rnd == 6'd63) n_state = S_ADD;
            S_ADD: begin
                if (!r_fin)     n_state = S_IDLE;
                else if (r_two) n_state = S_PADZ;
                else            n_state = S_OUT;
            end
            S_OUT:   if (i_ready && r_oidx == 3'd7) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_bits  <= '0;
            r_rnd   <= '0;
            r_fin   <= 1'b0;
            r_two   <= 1'b0;
            r_oidx  <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= InitHash[i];
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        if (i_req.action == ActAbsorb) begin
                            r_w[r_cnt[5:2]] <= {r_w[r_cnt[5:2]][23:0], i_req.data_byte};
                            r_bits <= r_bits + 64'd8;
                            r_cnt  <= r_cnt + 6'd1;
                            r_fin  <= 1'b0;
                        end else begin
                            r_w[r_cnt[5:2]] <= {r_w[r_cnt[5:2]][23:0], PadByte};
                            r_cnt <= r_cnt + 6'd1;
                            r_fin <= 1'b1;
                            r_two <= (r_cnt > 6'd55);
                        end
                        for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                        r_rnd <= '0;
                    end
                end
                S_PADZ: begin
                    r_w[r_cnt[5:2]] <= {r_w[r_cnt[5:2]][23:0], 8'h00};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd63) r_two <= 1'b1;
                end
                S_LEN: begin
                    r_w[r_cnt[5:2]] <= {r_w[r_cnt[5:2]][23:0],
                        r_bits[(7 - (r_cnt - LenStart)) * 8 +: 8]};
                    r_cnt <= r_cnt + 6'd1;
                end
                S_ROUND: begin
                    r_v[7] <= r_v[6];
                    r_v[6] <= r_v[5];
                    r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + w_t1;
                    r_v[3] <= r_v[2];
                    r_v[2] <= r_v[1];
                    r_v[1] <= r_v[0];
                    r_v[0] <= w_t1 + w_t2;
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                    r_w[15] <= w_new;
                    r_rnd <= r_rnd + 6'd1;
                end
                S_ADD: begin
                    for (int i = 0; i < 8; i++) begin
                        r_h[i] <= r_h[i] + r_v[i];
                        r_v[i] <= r_h[i] + r_v[i];
                    end
                    r_rnd  <= '0;
                    r_oidx <= '0;
                    if (r_fin && r_two) r_two <= 1'b0;
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (r_oidx == 3'd7) begin
                            for (int i = 0; i < 8; i++) r_h[i] <= InitHash[i];
                            r_cnt  <= '0;
                            r_bits <= '0;
                            r_fin  <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(r_oidx)))
        else $error("digest word dropped");
    a_round_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD) |-> (r_cnt == 6'd0)) else $error("block not full");
    a_out_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last_word) |=> (r_cnt == 6'd0 && r_bits == 64'd0))
        else $error("counters not cleared");

endmodule
